@@ src/sla_pkg.sv @@
// Package for the serial line assembler: constants, state encoding and the
// command/status structs shared by the controller and the datapath.
// No dependencies.
package sla_pkg;

  localparam int LINE_MAX_DEFAULT = 64;
  localparam int IDLE_W           = 16;
  localparam int DATA_W           = 8;
  localparam int KIND_W           = 2;

  localparam logic [IDLE_W-1:0] TIMEOUT_RESET = 16'd100;
  localparam logic [IDLE_W-1:0] IDLE_MAX      = 16'hFFFF;

  localparam logic [DATA_W-1:0] CHAR_CR = 8'h0D;
  localparam logic [DATA_W-1:0] CHAR_LF = 8'h0A;

  localparam logic [KIND_W-1:0] KIND_ECHO     = 2'd0;
  localparam logic [KIND_W-1:0] KIND_LINE     = 2'd1;
  localparam logic [KIND_W-1:0] KIND_OVERFLOW = 2'd2;

  localparam logic OP_BYTE = 1'b0;
  localparam logic OP_TICK = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_OVF,
    ST_RD,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic accept;
    logic load_echo;
    logic store_byte;
    logic load_ovf;
    logic load_line;
    logic clear_fill;
    logic rd_en;
    logic idx_clear;
    logic idx_inc;
  } cmd_t;

  typedef struct packed {
    logic op_tick;
    logic is_eol;
    logic fill_zero;
    logic fill_full;
    logic flush_due;
    logic out_free;
    logic line_end;
  } sts_t;

endpackage

@@ src/sla_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module sla_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 63,
  parameter int AW    = 6
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ src/sla_ctrl.sv @@
// Controller state machine of the serial line assembler.
// Depends on sla_pkg; drives commands to sla_dp and reads its status.
module sla_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  sla_pkg::sts_t sts,
  output sla_pkg::cmd_t cmd
);

  sla_pkg::state_t state;
  sla_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= sla_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    case (state)
      sla_pkg::ST_IDLE: begin
        in_ready   = 1'b1;
        cmd.accept = in_valid;
        if (in_valid) begin
          state_next = sla_pkg::ST_EXEC;
        end
      end
      sla_pkg::ST_EXEC: begin
        if (sts.op_tick) begin
          if (sts.flush_due) begin
            cmd.idx_clear = 1'b1;
            state_next    = sla_pkg::ST_RD;
          end else begin
            state_next = sla_pkg::ST_IDLE;
          end
        end else if (sts.out_free) begin
          cmd.load_echo = 1'b1;
          if (sts.is_eol) begin
            if (sts.fill_zero) begin
              state_next = sla_pkg::ST_IDLE;
            end else begin
              cmd.idx_clear = 1'b1;
              state_next    = sla_pkg::ST_RD;
            end
          end else if (!sts.fill_full) begin
            cmd.store_byte = 1'b1;
            state_next     = sla_pkg::ST_IDLE;
          end else begin
            state_next = sla_pkg::ST_OVF;
          end
        end
      end
      sla_pkg::ST_OVF: begin
        if (sts.out_free) begin
          cmd.load_ovf   = 1'b1;
          cmd.clear_fill = 1'b1;
          state_next     = sla_pkg::ST_IDLE;
        end
      end
      sla_pkg::ST_RD: begin
        cmd.rd_en  = 1'b1;
        state_next = sla_pkg::ST_OUT;
      end
      sla_pkg::ST_OUT: begin
        if (sts.out_free) begin
          cmd.load_line = 1'b1;
          if (sts.line_end) begin
            cmd.clear_fill = 1'b1;
            state_next     = sla_pkg::ST_IDLE;
          end else begin
            cmd.idx_inc = 1'b1;
            state_next  = sla_pkg::ST_RD;
          end
        end
      end
      default: begin
        state_next = sla_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

@@ src/sla_dp.sv @@
// Datapath of the serial line assembler: item latch, fill and idle counters,
// timeout register, line store and output word register.
// Depends on sla_pkg and sla_ram.
module sla_dp #(
  parameter int LINE_MAX = sla_pkg::LINE_MAX_DEFAULT
) (
  input  logic                          clk,
  input  logic                          rst,
  input  sla_pkg::cmd_t                 cmd,
  output sla_pkg::sts_t                 sts,
  input  logic                          in_op,
  input  logic [sla_pkg::DATA_W-1:0]    in_byte,
  input  logic                          in_route,
  input  logic                          cfg_wen,
  input  logic [sla_pkg::IDLE_W-1:0]    cfg_wdata,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [sla_pkg::DATA_W-1:0]    out_data,
  output logic [sla_pkg::KIND_W-1:0]    out_kind,
  output logic                          out_route,
  output logic                          out_last
);

  localparam int DEPTH = LINE_MAX - 1;
  localparam int FW    = $clog2(LINE_MAX);
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam logic [FW-1:0] CAP = FW'(DEPTH);

  logic                         op;
  logic [sla_pkg::DATA_W-1:0]   rx;
  logic                         route;
  logic [FW-1:0]                fill;
  logic [AW-1:0]                idx;
  logic [sla_pkg::IDLE_W-1:0]   idle;
  logic [sla_pkg::IDLE_W-1:0]   timeout;
  logic [sla_pkg::IDLE_W-1:0]   limit;
  logic [sla_pkg::DATA_W-1:0]   rd_data;
  logic                         out_free;

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      op    <= in_op;
      rx    <= in_byte;
      route <= in_route;
    end
    if (cmd.idx_clear) begin
      idx <= '0;
    end else if (cmd.idx_inc) begin
      idx <= idx + AW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill    <= '0;
      idle    <= '0;
      timeout <= sla_pkg::TIMEOUT_RESET;
    end else begin
      if (cfg_wen) begin
        timeout <= cfg_wdata;
      end
      if (cmd.accept) begin
        if (in_op == sla_pkg::OP_BYTE) begin
          idle <= '0;
        end else if (idle != sla_pkg::IDLE_MAX) begin
          idle <= idle + sla_pkg::IDLE_W'(1);
        end
      end
      if (cmd.clear_fill) begin
        fill <= '0;
      end else if (cmd.store_byte) begin
        fill <= fill + FW'(1);
      end
    end
  end

  sla_ram #(
    .WIDTH (sla_pkg::DATA_W),
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_store (
    .clk   (clk),
    .we    (cmd.store_byte),
    .waddr (fill[AW-1:0]),
    .wdata (rx),
    .re    (cmd.rd_en),
    .raddr (idx),
    .rdata (rd_data)
  );

  assign limit    = (timeout == '0) ? sla_pkg::IDLE_W'(1) : timeout;
  assign out_free = !out_valid || out_ready;

  always_comb begin
    sts.op_tick   = (op == sla_pkg::OP_TICK);
    sts.is_eol    = (rx == sla_pkg::CHAR_CR) || (rx == sla_pkg::CHAR_LF);
    sts.fill_zero = (fill == '0);
    sts.fill_full = (fill == CAP);
    sts.flush_due = (fill != '0) && (idle >= limit);
    sts.out_free  = out_free;
    sts.line_end  = ((FW'(idx) + FW'(1)) == fill);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_echo || cmd.load_ovf || cmd.load_line) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_echo) begin
      out_data  <= rx;
      out_kind  <= sla_pkg::KIND_ECHO;
      out_route <= 1'b0;
      out_last  <= sts.is_eol ? sts.fill_zero : !sts.fill_full;
    end else if (cmd.load_ovf) begin
      out_data  <= '0;
      out_kind  <= sla_pkg::KIND_OVERFLOW;
      out_route <= 1'b0;
      out_last  <= 1'b1;
    end else if (cmd.load_line) begin
      out_data  <= rd_data;
      out_kind  <= sla_pkg::KIND_LINE;
      out_route <= route;
      out_last  <= sts.line_end;
    end
  end

  a_fill_cap: assert property (@(posedge clk) disable iff (rst) fill <= CAP)
    else $error("line store fill above capacity");
  a_load_one: assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.load_echo, cmd.load_ovf, cmd.load_line}))
    else $error("more than one output load");
  a_load_free: assert property (@(posedge clk) disable iff (rst)
    (cmd.load_echo || cmd.load_ovf || cmd.load_line) |-> out_free)
    else $error("output word overwritten");
  a_store_room: assert property (@(posedge clk) disable iff (rst)
    cmd.store_byte |-> (fill < CAP))
    else $error("store into full line store");
  a_line_fill: assert property (@(posedge clk) disable iff (rst)
    cmd.load_line |-> (fill != '0))
    else $error("line byte loaded from an empty store");

endmodule

@@ src/serial_line_assembler_idle_flush.sv @@
// Serial line assembler with idle flush: top level.
// Depends on sla_pkg, sla_ctrl and sla_dp.
//
// Input words carry a received byte (s_tuser[0] = 0) or one time tick
// (s_tuser[0] = 1). Every byte is echoed on the output channel. Bytes other
// than CR or LF build up a line; CR or LF ends a non-empty line, which then
// leaves byte by byte with its route bit (m_tuser[2]). A byte arriving on a
// full store drops the line and gives an overflow word. Ticks advance an idle
// counter; a partial line idle for cfg_wdata ticks (0 acts as 1) is flushed.
// m_tlast marks the final output word caused by one input word.
// Order: a taken word is latched; in ST_EXEC a byte is loaded as its echo, and
// a plain byte or a tick that flushes nothing returns to ST_IDLE, where s_tready
// rises again. An overflow passes through ST_OVF; a line flush reads each line
// byte from the line store (registered read) in ST_RD and sends it from ST_OUT.
// Reset clears the fill count, the idle count and the output valid flag, and sets
// the timeout to 100. A stalled receiver holds the output word; the block
// keeps taking ticks that flush nothing, and holds s_tready low from the
// first word that needs the output until room opens.
module serial_line_assembler_idle_flush #(
  parameter int LINE_MAX = sla_pkg::LINE_MAX_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // rx_byte
  input  logic [1:0]  s_tuser,   // operation, protocol_active
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata,   // data_byte
  output logic [2:0]  m_tuser,   // kind[1:0], route
  output logic        m_tlast,
  input  logic        cfg_wen,
  input  logic [15:0] cfg_wdata
);

  sla_pkg::cmd_t cmd;
  sla_pkg::sts_t sts;

  sla_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  sla_dp #(
    .LINE_MAX (LINE_MAX)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .sts       (sts),
    .in_op     (s_tuser[0]),
    .in_byte   (s_tdata),
    .in_route  (s_tuser[1]),
    .cfg_wen   (cfg_wen),
    .cfg_wdata (cfg_wdata),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_data  (m_tdata),
    .out_kind  (m_tuser[1:0]),
    .out_route (m_tuser[2]),
    .out_last  (m_tlast)
  );

endmodule

@@ tb/tb_serial_line_assembler_idle_flush.sv @@
// Self-checking testbench for serial_line_assembler_idle_flush: streams bytes and ticks
// in, predicts echo, line and overflow words, and checks every output word in order.
// Depends on sla_pkg and the serial_line_assembler_idle_flush RTL.
module tb_serial_line_assembler_idle_flush;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LINE_MAX    = sla_pkg::LINE_MAX_DEFAULT;
  localparam int QUIET_LIMIT = 2000;
  localparam int HOLD_OFF    = 300;
  localparam int SETTLE      = 8;
  localparam int ITEMS_TOTAL = 260;

  typedef struct packed {
    logic [sla_pkg::KIND_W-1:0] kind;
    logic [7:0]                 data;
    logic                       route;
    logic                       last;
  } out_word_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = '0;   // rx_byte
  logic [1:0]  s_tuser = '0;   // operation, protocol_active
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [7:0]  m_tdata;        // data_byte
  logic [2:0]  m_tuser;        // kind[1:0], route
  logic        m_tlast;
  logic        cfg_wen = 1'b0;
  logic [15:0] cfg_wdata = '0;

  out_word_t   owed_words[$];
  logic [7:0]  held_line[0:LINE_MAX-2];
  int          fill_cnt = 0;
  logic [15:0] idle_ticks = '0;
  logic [15:0] timeout_reg = sla_pkg::TIMEOUT_RESET;

  bit in_burst = 0;
  bit out_burst = 0;
  int hold_cycles = 0;
  int quiet_cycles = 0;
  int errors = 0;
  int n_bytes = 0, n_ticks = 0, n_lines = 0, n_idle_flush = 0, n_overflow = 0;
  int n_cfg_writes = 0;

  serial_line_assembler_idle_flush #(.LINE_MAX(LINE_MAX)) DUT (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .m_tlast(m_tlast),
    .cfg_wen(cfg_wen), .cfg_wdata(cfg_wdata)
  );

  always #5 clk = ~clk;

  task automatic push_word(input logic [sla_pkg::KIND_W-1:0] kind,
                           input logic [7:0] data, input logic route, input logic last);
    owed_words.push_back('{kind: kind, data: data, route: route, last: last});
  endtask

  task automatic emit_line(input logic route);
    for (int i = 0; i < fill_cnt; i++)
      push_word(sla_pkg::KIND_LINE, held_line[i], route, i == fill_cnt - 1);
    fill_cnt = 0;
    n_lines++;
  endtask

  task automatic assemble_step(input logic op, input logic [7:0] ch, input logic proto);
    logic [15:0] limit;
    if (op == sla_pkg::OP_BYTE) begin
      n_bytes++;
      idle_ticks = '0;
      if (ch == sla_pkg::CHAR_CR || ch == sla_pkg::CHAR_LF) begin
        if (fill_cnt != 0) begin
          push_word(sla_pkg::KIND_ECHO, ch, 1'b0, 1'b0);
          emit_line(proto);
        end else begin
          push_word(sla_pkg::KIND_ECHO, ch, 1'b0, 1'b1);
        end
      end else if (fill_cnt < LINE_MAX - 1) begin
        held_line[fill_cnt] = ch;
        fill_cnt++;
        push_word(sla_pkg::KIND_ECHO, ch, 1'b0, 1'b1);
      end else begin
        push_word(sla_pkg::KIND_ECHO, ch, 1'b0, 1'b0);
        push_word(sla_pkg::KIND_OVERFLOW, 8'h00, 1'b0, 1'b1);
        fill_cnt = 0;
        n_overflow++;
      end
    end else begin
      n_ticks++;
      limit = (timeout_reg == 16'd0) ? 16'd1 : timeout_reg;
      if (idle_ticks != sla_pkg::IDLE_MAX) idle_ticks++;
      if (fill_cnt != 0 && idle_ticks >= limit) begin
        emit_line(proto);
        n_idle_flush++;
      end
    end
  endtask

  task automatic send_word(input logic op, input logic [7:0] ch, input logic proto);
    int gap;
    gap = in_burst ? 0 : $urandom_range(0, 16);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= ch;
    s_tuser  <= {proto, op};
    do @(posedge clk); while (!s_tready);
    assemble_step(op, ch, proto);
  endtask

  task automatic wait_drained();
    s_tvalid <= 1'b0;
    while (owed_words.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic set_timeout(input logic [15:0] value);
    wait_drained();
    cfg_wen   <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_wen   <= 1'b0;
    timeout_reg = value;
    n_cfg_writes++;
  endtask

  function automatic logic [7:0] plain_byte();
    logic [7:0] b;
    b = 8'($urandom_range(0, 255));
    if (b == sla_pkg::CHAR_CR || b == sla_pkg::CHAR_LF) b = b ^ 8'h40;
    return b;
  endfunction

  task automatic send_line(input int len);
    repeat (len) send_word(sla_pkg::OP_BYTE, plain_byte(), 1'($urandom_range(0, 1)));
  endtask

  task automatic test_reset_timeout();
    in_burst = 1;
    send_word(sla_pkg::OP_BYTE, 8'h41, 1'b0);
    repeat (sla_pkg::TIMEOUT_RESET)
      send_word(sla_pkg::OP_TICK, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
    in_burst = 0;
    wait_drained();
  endtask

  task automatic test_directed_lines();
    send_word(sla_pkg::OP_BYTE, sla_pkg::CHAR_CR, 1'b1);
    send_word(sla_pkg::OP_BYTE, sla_pkg::CHAR_LF, 1'b0);
    send_word(sla_pkg::OP_BYTE, 8'h00, 1'b0);
    send_word(sla_pkg::OP_BYTE, 8'hFF, 1'b1);
    send_word(sla_pkg::OP_BYTE, 8'h55, 1'b0);
    send_word(sla_pkg::OP_BYTE, 8'hAA, 1'b1);
    send_word(sla_pkg::OP_BYTE, sla_pkg::CHAR_CR, 1'b1);
    send_word(sla_pkg::OP_BYTE, 8'h7F, 1'b1);
    send_word(sla_pkg::OP_BYTE, 8'h80, 1'b0);
    send_word(sla_pkg::OP_BYTE, sla_pkg::CHAR_LF, 1'b0);
    send_word(sla_pkg::OP_BYTE, sla_pkg::CHAR_LF, 1'b1);
    wait_drained();
  endtask

  task automatic test_idle_flush();
    set_timeout(16'd0);
    send_word(sla_pkg::OP_BYTE, 8'h31, 1'b0);
    send_word(sla_pkg::OP_TICK, 8'h00, 1'b1);
    set_timeout(16'd1);
    send_word(sla_pkg::OP_TICK, 8'hFF, 1'b0);
    send_word(sla_pkg::OP_BYTE, 8'h61, 1'b1);
    send_word(sla_pkg::OP_BYTE, 8'h62, 1'b0);
    send_word(sla_pkg::OP_TICK, 8'h00, 1'b0);
    set_timeout(16'd3);
    send_word(sla_pkg::OP_BYTE, 8'h78, 1'b0);
    send_word(sla_pkg::OP_TICK, 8'h00, 1'b0);
    send_word(sla_pkg::OP_TICK, 8'h00, 1'b1);
    send_word(sla_pkg::OP_BYTE, 8'h79, 1'b0);
    repeat (4) send_word(sla_pkg::OP_TICK, 8'h00, 1'b1);
    wait_drained();
  endtask

  task automatic test_overflow();
    send_line(LINE_MAX - 1);
    send_word(sla_pkg::OP_BYTE, plain_byte(), 1'b0);
    send_word(sla_pkg::OP_BYTE, sla_pkg::CHAR_LF, 1'b1);
    wait_drained();
  endtask

  task automatic test_backpressure();
    hold_cycles = HOLD_OFF;
    send_line(20);
    send_word(sla_pkg::OP_BYTE, sla_pkg::CHAR_CR, 1'($urandom_range(0, 1)));
    wait_drained();
  endtask

  task automatic test_longest_timeout();
    set_timeout(sla_pkg::IDLE_MAX);
    in_burst  = 1;
    out_burst = 1;
    send_word(sla_pkg::OP_BYTE, 8'h5A, 1'b0);
    repeat (8)
      send_word(sla_pkg::OP_TICK, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
    send_word(sla_pkg::OP_BYTE, sla_pkg::CHAR_LF, 1'b1);
    in_burst  = 0;
    out_burst = 0;
    wait_drained();
  endtask

  task automatic test_random();
    int pick;
    int n;
    set_timeout(16'($urandom_range(1, 8)));
    while (n_bytes + n_ticks < ITEMS_TOTAL) begin
      in_burst  = ($urandom_range(0, 3) == 0);
      out_burst = ($urandom_range(0, 3) == 0);
      pick = $urandom_range(0, 18);
      if (pick < 11) begin
        send_line($urandom_range(0, 10));
        send_word(sla_pkg::OP_BYTE,
                  $urandom_range(0, 1) ? sla_pkg::CHAR_CR : sla_pkg::CHAR_LF,
                  1'($urandom_range(0, 1)));
      end else if (pick < 15) begin
        send_line($urandom_range(1, 8));
        n = $urandom_range(0, (timeout_reg == 16'd0) ? 2 : int'(timeout_reg) + 1);
        repeat (n)
          send_word(sla_pkg::OP_TICK, 8'($urandom_range(0, 255)),
                    1'($urandom_range(0, 1)));
      end else if (pick < 18) begin
        repeat ($urandom_range(1, 6)) begin
          n = $urandom_range(0, 3);
          send_word(1'($urandom_range(0, 1)),
                    n == 0 ? sla_pkg::CHAR_CR :
                    n == 1 ? sla_pkg::CHAR_LF : 8'($urandom_range(0, 255)),
                    1'($urandom_range(0, 1)));
        end
      end else begin
        set_timeout(16'($urandom_range(0, 8)));
      end
    end
    in_burst  = 0;
    out_burst = 0;
    wait_drained();
  endtask

  initial begin
    int w;
    @(negedge rst);
    forever begin
      if (hold_cycles > 0) begin
        m_tready <= 1'b0;
        repeat (hold_cycles) @(posedge clk);
        hold_cycles = 0;
      end
      w = out_burst ? 0 : $urandom_range(0, 16);
      if (w > 0) begin
        m_tready <= 1'b0;
        repeat (w) @(posedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (!m_tvalid && hold_cycles == 0);
    end
  end

  always @(posedge clk) begin
    out_word_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (owed_words.size() == 0) begin
        $error("unexpected word: kind %0d data %02h route %0b last %0b",
               m_tuser[1:0], m_tdata, m_tuser[2], m_tlast);
        errors++;
      end else begin
        want = owed_words.pop_front();
        if (m_tuser[1:0] !== want.kind) begin
          $error("kind: expected %0d, got %0d", want.kind, m_tuser[1:0]);
          errors++;
        end
        if (m_tdata !== want.data) begin
          $error("data_byte: expected %02h, got %02h", want.data, m_tdata);
          errors++;
        end
        if (m_tuser[2] !== want.route) begin
          $error("route: expected %0b, got %0b", want.route, m_tuser[2]);
          errors++;
        end
        if (m_tlast !== want.last) begin
          $error("last: expected %0b, got %0b", want.last, m_tlast);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Timeout: no word moved for %0d cycles, %0d words outstanding",
               QUIET_LIMIT, owed_words.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_timeout();
    test_directed_lines();
    test_idle_flush();
    test_overflow();
    test_backpressure();
    test_longest_timeout();
    test_random();
    wait_drained();
    repeat (20) @(posedge clk);
    $display("Covered %0d bytes and %0d ticks over %0d timeout writes:", n_bytes, n_ticks,
             n_cfg_writes);
    $display("%0d lines out (%0d on idle timeout), %0d overflow drops", n_lines,
             n_idle_flush, n_overflow);
    if (errors == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
